/* src/rrts_pkg.sv */
// rrts_pkg: shared types and codes for the round-robin thread scheduler.
// Used by rrts_ready_fifo, round_robin_thread_scheduler and the testbench. No dependencies.
package rrts_pkg;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_SPAWN     = 3'd1;
    localparam logic [2:0] CMD_TERMINATE = 3'd2;
    localparam logic [2:0] CMD_BLOCK     = 3'd3;
    localparam logic [2:0] CMD_RESUME    = 3'd4;
    localparam logic [2:0] CMD_SLEEP     = 3'd5;
    localparam logic [2:0] CMD_QUERY     = 3'd6;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_ID    = 3'd1;
    localparam logic [2:0] STAT_NO_SLOT   = 3'd2;
    localparam logic [2:0] STAT_MAIN_DENY = 3'd3;
    localparam logic [2:0] STAT_MAIN_TERM = 3'd4;

    typedef enum logic [1:0] {
        SLOT_READY,
        SLOT_RUNNING,
        SLOT_BLOCKED
    } slot_st_t;

    // ready queue operations for one cycle; push and pop together rotate
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

/* src/rrts_ready_fifo.sv */
// rrts_ready_fifo: circular ready queue of slot ids, registered head read.
// Depends on rrts_pkg (fifo_ctl_t).
module rrts_ready_fifo #(
    parameter int THREADS = 16,
    parameter int IDW     = 4,
    parameter int CW      = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rrts_pkg::fifo_ctl_t ctl,
    input  logic [IDW-1:0]     wdata,
    output logic [IDW-1:0]     rdata,
    output logic [CW-1:0]      count
);

    logic [IDW-1:0] mem [THREADS];
    logic [IDW-1:0] head_reg;
    logic [CW-1:0]  count_reg;
    logic [IDW-1:0] rdata_reg;
    logic [CW:0]    tail_sum;
    logic [IDW-1:0] tail;
    logic           wr_en;

    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail     = (tail_sum >= (CW+1)'(THREADS)) ? IDW'(tail_sum - (CW+1)'(THREADS))
                                                      : IDW'(tail_sum);
    // a push into a full queue is dropped unless the head leaves in the same cycle
    assign wr_en    = ctl.push && ((count_reg < CW'(THREADS)) || ctl.pop);
    assign rdata    = rdata_reg;
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail] <= wdata;
        end
        rdata_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctl.pop)
            begin
                head_reg <= (head_reg == IDW'(THREADS - 1)) ? '0 : head_reg + IDW'(1);
            end
            if (wr_en && !ctl.pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.pop && !wr_en)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

/* src/rrts_quanta_mem.sv */
// rrts_quanta_mem: per-slot quanta counters, one shared address for a write and a registered read.
// No package dependencies.
module rrts_quanta_mem #(
    parameter int THREADS = 16,
    parameter int IDW     = 4
) (
    input  logic           clk,
    input  logic           we,
    input  logic [IDW-1:0] addr,
    input  logic [31:0]    wdata,
    output logic [31:0]    rdata
);

    logic [31:0] mem [THREADS];
    logic [31:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

/* src/round_robin_thread_scheduler.sv */
// round_robin_thread_scheduler: slot table, command sequencer, output register.
// Depends on rrts_pkg, rrts_ready_fifo, rrts_quanta_mem.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | in        | in_valid/in_stall   | command, thread_id, sleep_quanta
//   out     | out       | out_valid/out_stall | status, value, running_id, total_quanta
//
// One item at a time. Tick and sleep, and block or terminate of the runner, each walk
// every slot once for the sleep countdown. Spawn walks up to THREADS slots; block or
// terminate of a ready thread rotates the ready queue, one entry at a time. A new
// item is taken only in S_IDLE, after the last result is loaded. in_stall is high from
// accept until the result is loaded into the output register, which holds it under
// out_stall.
// Reset restores slot 0 running, all other slots free, empty ready queue.
module round_robin_thread_scheduler #(
    parameter int THREADS    = 16,
    parameter int SLEEP_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [3:0]  thread_id,
    input  logic [15:0] sleep_quanta,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] value,
    output logic [3:0]  running_id,
    output logic [31:0] total_quanta
);

    localparam int IDW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW  = $clog2(THREADS + 1);
    localparam logic [32:0] SMAX = (33'(1) << SLEEP_BITS) - 33'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SRCH, S_CD, S_RUNQ, S_SLP, S_POPW, S_POP,
        S_QW, S_QINC, S_RMW, S_RMS, S_RES, S_QRD, S_DONE
    } seq_t;

    seq_t                 state_reg;
    logic [2:0]           cmd_reg;
    logic [3:0]           tid_reg;
    logic [15:0]          sq_reg;
    logic [IDW-1:0]       sel_reg;
    logic [IDW-1:0]       cur_reg;
    logic [31:0]          total_reg;
    logic [CW-1:0]        n_reg;
    logic                 q0w_reg;
    logic [THREADS-1:0]   valid_reg;
    rrts_pkg::slot_st_t   slot_reg [THREADS];
    logic [SLEEP_BITS-1:0] sleep_reg [THREADS];
    logic [2:0]           res_status_reg;
    logic [31:0]          res_value_reg;
    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic [31:0]          value_reg;
    logic [3:0]           running_reg;
    logic [31:0]          total_out_reg;

    rrts_pkg::fifo_ctl_t  fctl;
    logic [IDW-1:0]       fwdata;
    logic [IDW-1:0]       frdata;
    logic [CW-1:0]        fcount;
    logic                 qwe;
    logic [31:0]          qwdata;
    logic [31:0]          qrdata;
    logic [31:0]          qval;
    logic                 tid_ok;
    logic                 cd_hit;
    logic [32:0]          sq_sat;
    logic [IDW-1:0]       pop_id;

    rrts_ready_fifo #(.THREADS(THREADS), .IDW(IDW), .CW(CW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .wdata (fwdata),
        .rdata (frdata),
        .count (fcount)
    );

    rrts_quanta_mem #(.THREADS(THREADS), .IDW(IDW)) u_qmem (
        .clk   (clk),
        .we    (qwe),
        .addr  (sel_reg),
        .wdata (qwdata),
        .rdata (qrdata)
    );

    // slot 0 starts with one quantum and is never spawned, so it has no write until its first increment
    assign qval   = (sel_reg == '0 && !q0w_reg) ? 32'd1 : qrdata;
    assign tid_ok = (32'(tid_reg) < 32'(THREADS)) && valid_reg[sel_reg];
    assign cd_hit = valid_reg[sel_reg] && (sleep_reg[sel_reg] != '0);
    assign sq_sat = (sq_reg == 16'd0) ? 33'd1 :
                    ((33'(sq_reg) > SMAX) ? SMAX : 33'(sq_reg));
    assign pop_id = (fcount != '0) ? frdata : '0;

    always_comb
    begin
        fctl   = '0;
        fwdata = sel_reg;
        qwe    = 1'b0;
        qwdata = qval + 32'd1;
        case (state_reg)
            S_DISP:
            begin
                fctl.clear = (cmd_reg == rrts_pkg::CMD_TERMINATE) && tid_ok
                             && (sel_reg == '0);
            end
            S_SRCH:
            begin
                fctl.push = !valid_reg[sel_reg];
                qwe       = !valid_reg[sel_reg];
                qwdata    = 32'd0;
            end
            S_CD:
            begin
                fctl.push = cd_hit && (sleep_reg[sel_reg] == SLEEP_BITS'(1))
                            && (slot_reg[sel_reg] == rrts_pkg::SLOT_READY);
            end
            S_RUNQ:
            begin
                fctl.push = 1'b1;
                fwdata    = cur_reg;
            end
            S_RES:
            begin
                fctl.push = (slot_reg[sel_reg] == rrts_pkg::SLOT_BLOCKED)
                            && (sleep_reg[sel_reg] == '0);
            end
            S_RMS:
            begin
                fctl.pop  = 1'b1;
                fctl.push = (frdata != IDW'(tid_reg));
                fwdata    = frdata;
            end
            S_POP:
            begin
                fctl.pop = (fcount != '0);
            end
            S_QINC:
            begin
                qwe = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= rrts_pkg::CMD_TICK;
            tid_reg        <= '0;
            sq_reg         <= '0;
            sel_reg        <= '0;
            cur_reg        <= '0;
            total_reg      <= 32'd1;
            n_reg          <= '0;
            q0w_reg        <= 1'b0;
            valid_reg      <= THREADS'(1);
            for (int i = 0; i < THREADS; i++)
            begin
                slot_reg[i]  <= (i == 0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_READY;
                sleep_reg[i] <= '0;
            end
            res_status_reg <= rrts_pkg::STAT_OK;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            value_reg      <= '0;
            running_reg    <= '0;
            total_out_reg  <= '0;
        end
        else
        begin
            // a result waiting in S_DONE reloads the register itself
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg        <= command;
                        tid_reg        <= thread_id;
                        sq_reg         <= sleep_quanta;
                        sel_reg        <= IDW'(thread_id);
                        res_status_reg <= rrts_pkg::STAT_OK;
                        res_value_reg  <= '0;
                        state_reg      <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    case (cmd_reg)
                        rrts_pkg::CMD_TICK:
                        begin
                            sel_reg   <= '0;
                            state_reg <= S_CD;
                        end
                        rrts_pkg::CMD_SPAWN:
                        begin
                            sel_reg   <= '0;
                            state_reg <= S_SRCH;
                        end
                        rrts_pkg::CMD_TERMINATE:
                        begin
                            if (!tid_ok)
                            begin
                                res_status_reg <= rrts_pkg::STAT_BAD_ID;
                                state_reg      <= S_DONE;
                            end
                            else if (sel_reg == '0)
                            begin
                                valid_reg <= THREADS'(1);
                                for (int i = 0; i < THREADS; i++)
                                begin
                                    slot_reg[i]  <= (i == 0) ? rrts_pkg::SLOT_RUNNING
                                                             : rrts_pkg::SLOT_READY;
                                    sleep_reg[i] <= '0;
                                end
                                q0w_reg        <= 1'b0;
                                cur_reg        <= '0;
                                total_reg      <= 32'd1;
                                res_status_reg <= rrts_pkg::STAT_MAIN_TERM;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                valid_reg[sel_reg] <= 1'b0;
                                slot_reg[sel_reg]  <= rrts_pkg::SLOT_READY;
                                sleep_reg[sel_reg] <= '0;
                                if (slot_reg[sel_reg] == rrts_pkg::SLOT_READY)
                                begin
                                    n_reg     <= fcount;
                                    state_reg <= (fcount == '0) ? S_DONE : S_RMW;
                                end
                                else if (sel_reg == cur_reg)
                                begin
                                    sel_reg   <= '0;
                                    state_reg <= S_CD;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                end
                            end
                        end
                        rrts_pkg::CMD_BLOCK:
                        begin
                            if (!tid_ok)
                            begin
                                res_status_reg <= rrts_pkg::STAT_BAD_ID;
                                state_reg      <= S_DONE;
                            end
                            else if (sel_reg == '0)
                            begin
                                res_status_reg <= rrts_pkg::STAT_MAIN_DENY;
                                state_reg      <= S_DONE;
                            end
                            else if (slot_reg[sel_reg] == rrts_pkg::SLOT_RUNNING)
                            begin
                                slot_reg[sel_reg] <= rrts_pkg::SLOT_BLOCKED;
                                sel_reg           <= '0;
                                state_reg         <= S_CD;
                            end
                            else if (slot_reg[sel_reg] == rrts_pkg::SLOT_READY)
                            begin
                                slot_reg[sel_reg] <= rrts_pkg::SLOT_BLOCKED;
                                n_reg             <= fcount;
                                state_reg         <= (fcount == '0) ? S_DONE : S_RMW;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        rrts_pkg::CMD_RESUME:
                        begin
                            if (!tid_ok)
                            begin
                                res_status_reg <= rrts_pkg::STAT_BAD_ID;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_RES;
                            end
                        end
                        rrts_pkg::CMD_SLEEP:
                        begin
                            if (cur_reg == '0)
                            begin
                                res_status_reg <= rrts_pkg::STAT_MAIN_DENY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                sel_reg   <= '0;
                                state_reg <= S_CD;
                            end
                        end
                        rrts_pkg::CMD_QUERY:
                        begin
                            if (!tid_ok)
                            begin
                                res_status_reg <= rrts_pkg::STAT_BAD_ID;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_QRD;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_SRCH:
                begin
                    if (!valid_reg[sel_reg])
                    begin
                        valid_reg[sel_reg] <= 1'b1;
                        slot_reg[sel_reg]  <= rrts_pkg::SLOT_READY;
                        sleep_reg[sel_reg] <= '0;
                        res_value_reg      <= 32'(sel_reg);
                        state_reg          <= S_DONE;
                    end
                    else if (sel_reg == IDW'(THREADS - 1))
                    begin
                        res_status_reg <= rrts_pkg::STAT_NO_SLOT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        sel_reg <= sel_reg + IDW'(1);
                    end
                end
                S_CD:
                begin
                    if (cd_hit)
                    begin
                        sleep_reg[sel_reg] <= sleep_reg[sel_reg] - SLEEP_BITS'(1);
                    end
                    if (sel_reg == IDW'(THREADS - 1))
                    begin
                        sel_reg <= cur_reg;
                        case (cmd_reg)
                            rrts_pkg::CMD_TICK:  state_reg <= S_RUNQ;
                            rrts_pkg::CMD_SLEEP: state_reg <= S_SLP;
                            default:             state_reg <= S_POPW;
                        endcase
                    end
                    else
                    begin
                        sel_reg <= sel_reg + IDW'(1);
                    end
                end
                S_RUNQ:
                begin
                    slot_reg[cur_reg] <= rrts_pkg::SLOT_READY;
                    state_reg         <= S_POPW;
                end
                S_SLP:
                begin
                    sleep_reg[sel_reg] <= SLEEP_BITS'(sq_sat);
                    slot_reg[sel_reg]  <= rrts_pkg::SLOT_READY;
                    state_reg          <= S_POPW;
                end
                S_POPW:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    cur_reg          <= pop_id;
                    sel_reg          <= pop_id;
                    slot_reg[pop_id] <= rrts_pkg::SLOT_RUNNING;
                    state_reg        <= S_QW;
                end
                S_QW:
                begin
                    state_reg <= S_QINC;
                end
                S_QINC:
                begin
                    if (sel_reg == '0)
                    begin
                        q0w_reg <= 1'b1;
                    end
                    total_reg <= total_reg + 32'd1;
                    state_reg <= S_DONE;
                end
                S_RMW:
                begin
                    state_reg <= S_RMS;
                end
                S_RMS:
                begin
                    n_reg     <= n_reg - CW'(1);
                    state_reg <= (n_reg == CW'(1)) ? S_DONE : S_RMW;
                end
                S_RES:
                begin
                    if (slot_reg[sel_reg] == rrts_pkg::SLOT_BLOCKED)
                    begin
                        slot_reg[sel_reg] <= rrts_pkg::SLOT_READY;
                    end
                    state_reg <= S_DONE;
                end
                S_QRD:
                begin
                    res_value_reg <= qval;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        value_reg     <= res_value_reg;
                        running_reg   <= 4'(cur_reg);
                        total_out_reg <= total_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value        = value_reg;
    assign running_id   = running_reg;
    assign total_quanta = total_out_reg;

    a_main_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0])
        else $error("main slot lost its valid flag");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fcount) <= 32'(THREADS))
        else $error("ready queue count above slot count");

    a_runner_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (slot_reg[cur_reg] == rrts_pkg::SLOT_RUNNING))
        else $error("running id does not point at a running slot");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DISP))
        else $error("accepted item not dispatched");

endmodule

/* tb/sv/round_robin_thread_scheduler_tb.sv */
// Self-checking testbench for round_robin_thread_scheduler.
// Depends on rrts_pkg; a scoreboard class tracks the slot table and predicts each result.
module round_robin_thread_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 16;
    localparam int LIMIT = 2000000;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [3:0]  running_id;
        logic [31:0] total_quanta;
    } sched_result_t;

    class sched_scoreboard;
        bit                 slot_used[NT];
        rrts_pkg::slot_st_t slot_mode[NT];
        logic [15:0]        sleep_left[NT];
        logic [31:0]        quanta_run[NT];
        logic [3:0]         ready_q[$];
        logic [3:0]         runner;
        logic [31:0]        quanta_sum;
        sched_result_t      pending[$];
        int                 errors;
        int                 checked;

        function void restart();
            for (int i = 0; i < NT; i++)
            begin
                slot_used[i] = 0;
                slot_mode[i] = rrts_pkg::SLOT_READY;
                sleep_left[i] = 0;
                quanta_run[i] = 0;
            end
            slot_used[0] = 1;
            slot_mode[0] = rrts_pkg::SLOT_RUNNING;
            quanta_run[0] = 1;
            ready_q.delete();
            runner = 0;
            quanta_sum = 1;
        endfunction

        function void enqueue(logic [3:0] id);
            if (ready_q.size() < NT)
                ready_q.insert(ready_q.size(), id);
        endfunction

        function void dequeue_id(logic [3:0] id);
            for (int i = ready_q.size() - 1; i >= 0; i--)
                if (ready_q[i] == id)
                    ready_q.delete(i);
        endfunction

        function void age_sleepers();
            for (int i = 0; i < NT; i++)
                if (slot_used[i] && sleep_left[i] != 0)
                begin
                    sleep_left[i]--;
                    if (sleep_left[i] == 0 && slot_mode[i] == rrts_pkg::SLOT_READY)
                        enqueue(i[3:0]);
                end
        endfunction

        function void dispatch_head();
            logic [3:0] id;
            id = 0;
            if (ready_q.size() > 0)
            begin
                id = ready_q[0];
                ready_q.delete(0);
            end
            runner = id;
            slot_mode[id] = rrts_pkg::SLOT_RUNNING;
            quanta_run[id]++;
            quanta_sum++;
        endfunction

        function bit id_live(logic [3:0] tid);
            return slot_used[tid];
        endfunction

        function void note_command(logic [2:0] cmd, logic [3:0] tid, logic [15:0] sq);
            sched_result_t r;
            int i;
            r.status = rrts_pkg::STAT_OK;
            r.value = 0;
            case (cmd)
                rrts_pkg::CMD_TICK:
                begin
                    age_sleepers();
                    slot_mode[runner] = rrts_pkg::SLOT_READY;
                    enqueue(runner);
                    dispatch_head();
                end
                rrts_pkg::CMD_SPAWN:
                begin
                    for (i = 0; i < NT && slot_used[i]; i++) ;
                    if (i >= NT)
                        r.status = rrts_pkg::STAT_NO_SLOT;
                    else
                    begin
                        slot_used[i] = 1;
                        slot_mode[i] = rrts_pkg::SLOT_READY;
                        sleep_left[i] = 0;
                        quanta_run[i] = 0;
                        enqueue(i[3:0]);
                        r.value = i;
                    end
                end
                rrts_pkg::CMD_TERMINATE:
                    if (!id_live(tid))
                        r.status = rrts_pkg::STAT_BAD_ID;
                    else if (tid == 0)
                    begin
                        restart();
                        r.status = rrts_pkg::STAT_MAIN_TERM;
                    end
                    else
                    begin
                        if (slot_mode[tid] == rrts_pkg::SLOT_READY)
                            dequeue_id(tid);
                        slot_used[tid] = 0;
                        slot_mode[tid] = rrts_pkg::SLOT_READY;
                        sleep_left[tid] = 0;
                        if (tid == runner)
                        begin
                            age_sleepers();
                            dispatch_head();
                        end
                    end
                rrts_pkg::CMD_BLOCK:
                    if (!id_live(tid))
                        r.status = rrts_pkg::STAT_BAD_ID;
                    else if (tid == 0)
                        r.status = rrts_pkg::STAT_MAIN_DENY;
                    else if (slot_mode[tid] == rrts_pkg::SLOT_RUNNING)
                    begin
                        slot_mode[tid] = rrts_pkg::SLOT_BLOCKED;
                        age_sleepers();
                        dispatch_head();
                    end
                    else if (slot_mode[tid] == rrts_pkg::SLOT_READY)
                    begin
                        slot_mode[tid] = rrts_pkg::SLOT_BLOCKED;
                        dequeue_id(tid);
                    end
                rrts_pkg::CMD_RESUME:
                    if (!id_live(tid))
                        r.status = rrts_pkg::STAT_BAD_ID;
                    else if (slot_mode[tid] == rrts_pkg::SLOT_BLOCKED)
                    begin
                        slot_mode[tid] = rrts_pkg::SLOT_READY;
                        if (sleep_left[tid] == 0)
                            enqueue(tid);
                    end
                rrts_pkg::CMD_SLEEP:
                    if (runner == 0)
                        r.status = rrts_pkg::STAT_MAIN_DENY;
                    else
                    begin
                        age_sleepers();
                        sleep_left[runner] = (sq == 0) ? 16'd1 : sq;
                        slot_mode[runner] = rrts_pkg::SLOT_READY;
                        dispatch_head();
                    end
                rrts_pkg::CMD_QUERY:
                    if (!id_live(tid))
                        r.status = rrts_pkg::STAT_BAD_ID;
                    else
                        r.value = quanta_run[tid];
                default: ;
            endcase
            r.running_id = runner;
            r.total_quanta = quanta_sum;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.status !== exp.status)
            begin
                $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
                errors++;
            end
            if (got.value !== exp.value)
            begin
                $display("%0t: value exp %0d got %0d", $realtime, exp.value, got.value);
                errors++;
            end
            if (got.running_id !== exp.running_id)
            begin
                $display("%0t: running_id exp %0d got %0d", $realtime, exp.running_id,
                         got.running_id);
                errors++;
            end
            if (got.total_quanta !== exp.total_quanta)
            begin
                $display("%0t: total_quanta exp %0d got %0d", $realtime, exp.total_quanta,
                         got.total_quanta);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [3:0]  thread_id;
    logic [15:0] sleep_quanta;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] value;
    logic [3:0]  running_id;
    logic [31:0] total_quanta;

    sched_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycles;
    int  sent;

    round_robin_thread_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .thread_id    (thread_id),
        .sleep_quanta (sleep_quanta),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .value        (value),
        .running_id   (running_id),
        .total_quanta (total_quanta)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: stall changes on the falling edge, items taken on the rising edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, value, running_id, total_quanta});
    end

    always @(posedge clk)
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_cmd(logic [2:0] cmd, logic [3:0] tid, logic [15:0] sq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        thread_id <= tid;
        sleep_quanta <= sq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_command(cmd, tid, sq);
        sent++;
        @(negedge clk);
    endtask

    // mostly well-formed commands with random ids, terminate of id 0 made rarer; the rest anything the fields allow
    task automatic send_random();
        logic [2:0]  cmd;
        logic [3:0]  tid;
        logic [15:0] sq;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)
            cmd = rrts_pkg::CMD_TICK;
        else if (pick < 48)
            cmd = rrts_pkg::CMD_SPAWN;
        else if (pick < 55)
            cmd = rrts_pkg::CMD_TERMINATE;
        else if (pick < 67)
            cmd = rrts_pkg::CMD_BLOCK;
        else if (pick < 80)
            cmd = rrts_pkg::CMD_RESUME;
        else if (pick < 88)
            cmd = rrts_pkg::CMD_SLEEP;
        else if (pick < 98)
            cmd = rrts_pkg::CMD_QUERY;
        else
            cmd = CMD_UNUSED;
        tid = 4'($urandom_range(15));
        if (cmd == rrts_pkg::CMD_TERMINATE && tid == 0 && $urandom_range(3) != 0)
            tid = 4'($urandom_range(15, 1));
        if ($urandom_range(3) != 0)
            sq = 16'($urandom_range(6));
        else
            sq = 16'($urandom);
        send_cmd(cmd, tid, sq);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        sb.restart();
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = rrts_pkg::CMD_TICK;
        thread_id = 0;
        sleep_quanta = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: main rules, full table, sleep extremes, resume of a ready thread, reset by terminate
        send_cmd(rrts_pkg::CMD_BLOCK, 4'd0, 16'd0);
        send_cmd(rrts_pkg::CMD_SLEEP, 4'd0, 16'd5);
        send_cmd(rrts_pkg::CMD_QUERY, 4'd15, 16'd0);
        send_cmd(rrts_pkg::CMD_RESUME, 4'd0, 16'd0);
        for (int i = 0; i < 16; i++)
            send_cmd(rrts_pkg::CMD_SPAWN, 4'd0, 16'd0);
        send_cmd(rrts_pkg::CMD_TICK, 4'd0, 16'hffff);
        send_cmd(rrts_pkg::CMD_SLEEP, 4'd0, 16'd0);
        send_cmd(rrts_pkg::CMD_TICK, 4'd0, 16'd0);
        send_cmd(rrts_pkg::CMD_SLEEP, 4'd0, 16'hffff);
        send_cmd(rrts_pkg::CMD_TICK, 4'd0, 16'd0);
        send_cmd(rrts_pkg::CMD_BLOCK, 4'd2, 16'd0);
        send_cmd(rrts_pkg::CMD_BLOCK, 4'd2, 16'd0);
        send_cmd(rrts_pkg::CMD_RESUME, 4'd1, 16'd0);
        send_cmd(rrts_pkg::CMD_QUERY, 4'd0, 16'd0);
        send_cmd(CMD_UNUSED, 4'd9, 16'd0);
        send_cmd(rrts_pkg::CMD_TERMINATE, 4'd0, 16'd0);
        send_cmd(rrts_pkg::CMD_TERMINATE, 4'd3, 16'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 68) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 68) : 0;
            for (int n = 0; n < 200; n++)
                send_random();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Ran %0d commands, checked %0d results across four idle/stall mixes",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* round_robin_thread_scheduler.f */
src/rrts_pkg.sv
src/rrts_ready_fifo.sv
src/rrts_quanta_mem.sv
src/round_robin_thread_scheduler.sv
tb/sv/round_robin_thread_scheduler_tb.sv
